/* hw/rtl/hduart_pkg.sv */
// ----------------------------------------------------------------------------
// hduart_pkg
// Shared types and constants for the half-duplex 8N1 UART.
// ----------------------------------------------------------------------------
package hduart_pkg;

  localparam int DATA_BITS = 8;
  localparam int TICK_W    = 16;
  localparam int BITCNT_W  = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SAMPLE = 1'd1;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_TAKE = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_RECEIVE  = 2'd1,
    MODE_TRANSMIT = 2'd2,
    MODE_PENDING  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic       rx_level;
  } in_beat_t;

  typedef struct packed {
    logic       tx_level;
    logic [1:0] mode_now;
    logic       send_accepted;
    logic       rx_done;
    logic [7:0] rx_byte;
  } out_beat_t;

  typedef struct packed {
    logic [TICK_W-1:0] bit_ticks;
    logic [TICK_W-1:0] first_sample_ticks;
  } cfg_t;

endpackage

/* hw/rtl/hduart_if.sv */
// ----------------------------------------------------------------------------
// hduart_if
// Valid/ready channels carrying input beats and result beats.
// ----------------------------------------------------------------------------
interface hduart_in_if;
  logic                 valid;
  logic                 ready;
  hduart_pkg::in_beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

interface hduart_out_if;
  logic                  valid;
  logic                  ready;
  hduart_pkg::out_beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

/* hw/rtl/hduart_cfg.sv */
// ----------------------------------------------------------------------------
// hduart_cfg
// Configuration registers for the bit period and the first sample delay.
// ----------------------------------------------------------------------------
module hduart_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [hduart_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hduart_pkg::CFG_W-1:0]         cfg_wdata,
  output hduart_pkg::cfg_t                     cfg
);

  hduart_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_ticks          <= 16'd16;
      cfg_r.first_sample_ticks <= 16'd24;
    end else if (cfg_we) begin
      case (cfg_index)
        hduart_pkg::CFG_BIT_TICKS:    cfg_r.bit_ticks          <= cfg_wdata;
        hduart_pkg::CFG_FIRST_SAMPLE: cfg_r.first_sample_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/hduart_in_reg.sv */
// ----------------------------------------------------------------------------
// hduart_in_reg
// Input register stage that holds one beat until the core takes it.
// ----------------------------------------------------------------------------
module hduart_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  hduart_in_if.sink            in_if,
  output logic                 s1_valid,
  output hduart_pkg::in_beat_t s1_beat,
  input  logic                 s1_take
);

  logic                 valid_r;
  hduart_pkg::in_beat_t beat_r;

  assign in_if.ready = !valid_r || s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      beat_r <= in_if.beat;
    end
  end

  assign s1_valid = valid_r;
  assign s1_beat  = beat_r;

endmodule

/* hw/rtl/hduart_core.sv */
// ----------------------------------------------------------------------------
// hduart_core
// UART state registers, one-tick next-state logic and the result register.
// ----------------------------------------------------------------------------
module hduart_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hduart_pkg::cfg_t     cfg,
  input  logic                 s1_valid,
  input  hduart_pkg::in_beat_t s1_beat,
  output logic                 s1_take,
  hduart_out_if.source         out_if
);

  localparam int DB = hduart_pkg::DATA_BITS;
  localparam int TW = hduart_pkg::TICK_W;
  localparam int BW = hduart_pkg::BITCNT_W;

  hduart_pkg::mode_t mode_r, mode_nxt;
  logic [TW-1:0]     tick_r, tick_nxt;
  logic [TW-1:0]     target_r, target_nxt;
  logic [DB-1:0]     tx_shift_r, tx_shift_nxt;
  logic [BW-1:0]     tx_bits_r, tx_bits_nxt;
  logic [DB-1:0]     rx_shift_r, rx_shift_nxt;
  logic [BW-1:0]     rx_bits_r, rx_bits_nxt;
  logic              rx_prev_r, rx_prev_nxt;
  logic              tx_line_r, tx_line_nxt;
  logic              out_valid_r;
  hduart_pkg::out_beat_t out_beat_r, out_beat_nxt;

  logic [TW-1:0] tick_inc;
  logic          fires;
  logic [15:0]   rx_wide;

  assign s1_take  = s1_valid && (!out_valid_r || out_if.ready);
  assign tick_inc = tick_r + 1'b1;
  assign fires    = (tick_inc >= target_r);

  always_comb begin
    logic accepted;
    logic done;
    mode_nxt     = mode_r;
    tick_nxt     = tick_r;
    target_nxt   = target_r;
    tx_shift_nxt = tx_shift_r;
    tx_bits_nxt  = tx_bits_r;
    rx_shift_nxt = rx_shift_r;
    rx_bits_nxt  = rx_bits_r;
    tx_line_nxt  = tx_line_r;
    accepted     = 1'b0;
    done         = 1'b0;

    case (mode_r)
      hduart_pkg::MODE_TRANSMIT: begin
        tick_nxt = fires ? '0 : tick_inc;
        if (fires) begin
          if (tx_bits_r < BW'(DB)) begin
            tx_line_nxt  = tx_shift_r[0];
            tx_shift_nxt = tx_shift_r >> 1;
            tx_bits_nxt  = tx_bits_r + 1'b1;
          end else begin
            tx_line_nxt = 1'b1;
            mode_nxt    = hduart_pkg::MODE_IDLE;
          end
        end
      end
      hduart_pkg::MODE_RECEIVE: begin
        tick_nxt = fires ? '0 : tick_inc;
        if (fires) begin
          target_nxt = cfg.bit_ticks;
          if (rx_bits_r < BW'(DB)) begin
            rx_bits_nxt  = rx_bits_r + 1'b1;
            rx_shift_nxt = {s1_beat.rx_level, rx_shift_r[DB-1:1]};
          end else begin
            mode_nxt = hduart_pkg::MODE_PENDING;
            done     = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if ((mode_nxt == hduart_pkg::MODE_IDLE || mode_nxt == hduart_pkg::MODE_PENDING) &&
        rx_prev_r && !s1_beat.rx_level) begin
      mode_nxt    = hduart_pkg::MODE_RECEIVE;
      tick_nxt    = '0;
      target_nxt  = cfg.first_sample_ticks;
      rx_bits_nxt = '0;
    end

    case (s1_beat.command)
      hduart_pkg::CMD_SEND: begin
        if (mode_nxt == hduart_pkg::MODE_IDLE) begin
          mode_nxt     = hduart_pkg::MODE_TRANSMIT;
          tx_shift_nxt = DB'(s1_beat.tx_byte);
          tx_bits_nxt  = '0;
          tick_nxt     = '0;
          target_nxt   = cfg.bit_ticks;
          tx_line_nxt  = 1'b0;
          accepted     = 1'b1;
        end
      end
      hduart_pkg::CMD_TAKE: begin
        if (mode_nxt == hduart_pkg::MODE_PENDING) begin
          mode_nxt = hduart_pkg::MODE_IDLE;
        end
      end
      default: ;
    endcase

    rx_prev_nxt = s1_beat.rx_level;

    rx_wide = 16'(rx_shift_nxt);
    out_beat_nxt.tx_level      = tx_line_nxt;
    out_beat_nxt.mode_now      = mode_nxt;
    out_beat_nxt.send_accepted = accepted;
    out_beat_nxt.rx_done       = done;
    out_beat_nxt.rx_byte       = rx_wide[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= hduart_pkg::MODE_IDLE;
      tick_r      <= '0;
      target_r    <= '0;
      tx_shift_r  <= '0;
      tx_bits_r   <= '0;
      rx_shift_r  <= '0;
      rx_bits_r   <= '0;
      rx_prev_r   <= 1'b1;
      tx_line_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        mode_r      <= mode_nxt;
        tick_r      <= tick_nxt;
        target_r    <= target_nxt;
        tx_shift_r  <= tx_shift_nxt;
        tx_bits_r   <= tx_bits_nxt;
        rx_shift_r  <= rx_shift_nxt;
        rx_bits_r   <= rx_bits_nxt;
        rx_prev_r   <= rx_prev_nxt;
        tx_line_r   <= tx_line_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.beat  = out_beat_r;

endmodule

/* hw/rtl/half_duplex_uart_8n1_top.sv */
// A beat is held in the input register, then its result in the core result register.
// One beat per cycle unless stalled; tick update is a single 16-bit add and compare.
// Stalls on the result side back up through the result and input registers.
// Reset: synchronous, active low; the UART returns to idle with both lines high,
// the bit period at 16 ticks and the first sample delay at 24 ticks.
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1_top
// Half-duplex 8N1 UART stepped by one timer tick per input beat.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1_top (
  input  logic                             clk,
  input  logic                             rst_n,
  hduart_in_if.sink                        in_if,
  hduart_out_if.source                     out_if,
  input  logic                             cfg_we,
  input  logic [hduart_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hduart_pkg::CFG_W-1:0]     cfg_wdata
);

  hduart_pkg::cfg_t     cfg;
  logic                 s1_valid;
  hduart_pkg::in_beat_t s1_beat;
  logic                 s1_take;

  hduart_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hduart_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat),
    .s1_take  (s1_take)
  );

  hduart_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat),
    .s1_take  (s1_take),
    .out_if   (out_if)
  );

endmodule
